[sv/ppnd_pkg.sv]
// Shared types and constants for the point-to-polyline distance block.
package ppnd_pkg;

  // Result width: distances are unsigned integers (Q32.0), saturating.
  localparam int DIST_W = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Integer root and quotient width.
  localparam int ROOT_W = 64;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [ROOT_W-1:0] ROOT_ONE = 64'h4000_0000_0000_0000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_Z = 2'd2;

  // Index of the last of three vector terms.
  localparam logic [1:0] TERM_LAST = 2'd2;

  // Per-vertex flags carried from front to back.
  typedef struct packed {
    logic seg_valid;
    logic first;
    logic last;
  } seg_flags_t;

  localparam int FLAGS_W = $bits(seg_flags_t);

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ_W,
    B_SQ_D,
    B_CHK_L,
    B_DOT,
    B_CHK_D,
    B_SQ_E,
    B_MUL_WL,
    B_MUL_DD,
    B_CHK_C,
    B_DIV,
    B_ROOT,
    B_OUT
  } back_state_t;

endpackage

[sv/ppnd_front.sv]
// Front end: probe registers, previous vertex, segment vectors and flags.
module ppnd_front #(
  parameter int COORD_WIDTH = 32,
  localparam int DW = COORD_WIDTH + 1,
  localparam int ENTRY_W = 9 * DW + ppnd_pkg::FLAGS_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0]   in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0]   in_vertex_z,
  input  logic                            in_first_vertex,
  input  logic                            in_last_vertex,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppnd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data,
  output logic                            q_push,
  input  logic                            q_full,
  output logic [ENTRY_W-1:0]              q_entry
);
  import ppnd_pkg::*;

  logic signed [COORD_WIDTH-1:0] probe_x_r, probe_y_r, probe_z_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                          have_prev_r;
  logic                          accept;
  seg_flags_t                    flags;
  logic signed [DW-1:0]          wx, wy, wz, dx, dy, dz, ex, ey, ez;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;
  assign q_push    = accept;

  // Probe registers and previous vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_x_r   <= '0;
      probe_y_r   <= '0;
      probe_z_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PROBE_X: probe_x_r <= cfg_data;
          CFG_PROBE_Y: probe_y_r <= cfg_data;
          CFG_PROBE_Z: probe_z_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        prev_x_r    <= in_vertex_x;
        prev_y_r    <= in_vertex_y;
        prev_z_r    <= in_vertex_z;
        have_prev_r <= ~in_last_vertex;
      end
    end
  end

  // Segment vectors: w = P - S, d = E - S, e = P - E
  always_comb begin
    wx = DW'(probe_x_r) - DW'(prev_x_r);
    wy = DW'(probe_y_r) - DW'(prev_y_r);
    wz = DW'(probe_z_r) - DW'(prev_z_r);
    dx = DW'(in_vertex_x) - DW'(prev_x_r);
    dy = DW'(in_vertex_y) - DW'(prev_y_r);
    dz = DW'(in_vertex_z) - DW'(prev_z_r);
    ex = DW'(probe_x_r) - DW'(in_vertex_x);
    ey = DW'(probe_y_r) - DW'(in_vertex_y);
    ez = DW'(probe_z_r) - DW'(in_vertex_z);
    flags.seg_valid = have_prev_r & ~in_first_vertex;
    flags.first     = in_first_vertex;
    flags.last      = in_last_vertex;
    q_entry = {flags, wx, wy, wz, dx, dy, dz, ex, ey, ez};
  end

endmodule

[sv/ppnd_fifo.sv]
// Two-entry queue between front end and back end.
module ppnd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic             v0_r, v1_r, v0_nxt, v1_nxt;
  logic [WIDTH-1:0] d0_r, d1_r, d0_nxt, d1_nxt;

  assign full  = v1_r;
  assign empty = ~v0_r;
  assign dout  = d0_r;

  // Head slot drains first, tail moves up on pop
  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      v0_nxt = v1_r;
      d0_nxt = d1_r;
      v1_nxt = 1'b0;
    end
    if (push) begin
      if (!v0_nxt) begin
        v0_nxt = 1'b1;
        d0_nxt = din;
      end else begin
        v1_nxt = 1'b1;
        d1_nxt = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n) !v0_r |-> !v1_r)
    else $error("tail slot valid without head");

endmodule

[sv/ppnd_back.sv]
// Back end: bit-serial multiply, long division and integer root sequencer.
module ppnd_back #(
  parameter int COORD_WIDTH = 32,
  localparam int DW = COORD_WIDTH + 1,
  localparam int ENTRY_W = 9 * DW + ppnd_pkg::FLAGS_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ENTRY_W-1:0]            q_entry,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ppnd_pkg::DIST_W-1:0]   out_segment_distance,
  output logic                          out_segment_valid,
  output logic [ppnd_pkg::DIST_W-1:0]   out_nearest_distance,
  output logic                          out_polyline_done
);
  import ppnd_pkg::*;

  localparam int MW = DW;
  localparam int SW = 2 * MW + 2;
  localparam int AW = 2 * SW + 1;
  localparam int XW = ((2 * SW > SW + ROOT_W + 1) ? 2 * SW : SW + ROOT_W + 1) + 1;

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] n;
    n = -x;
    return x[DW-1] ? MW'(n) : MW'(x);
  endfunction

  back_state_t state_r, state_nxt;
  seg_flags_t  flags_r, flags_nxt, entry_flags;

  logic signed [DW-1:0] w_r [3], d_r [3], e_r [3];
  logic signed [DW-1:0] w_nxt [3], d_nxt [3], e_nxt [3];
  logic [1:0]           k_r, k_nxt;
  logic                 mrun_r, mrun_nxt, msub_r, msub_nxt;
  logic [AW-1:0]        mula_r, mula_nxt;
  logic [SW-1:0]        mulb_r, mulb_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [SW-1:0]        ww_r, ww_nxt, ll_r, ll_nxt, dd_r, dd_nxt;
  logic [XW-1:0]        rem_r, rem_nxt, dv_r, dv_nxt;
  logic [ROOT_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ROOT_W-1:0]    x_r, x_nxt, res_r, res_nxt, one_r, one_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DIST_W-1:0]    seg_r, seg_nxt, min_r, min_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]    out_seg_r, out_seg_nxt, out_near_r, out_near_nxt;
  logic                 out_sv_r, out_sv_nxt, out_done_r, out_done_nxt;

  // Shared decisions
  logic              is_mul, mul_done, last_term, term_done;
  logic              ll_zero, d_nonpos, dd_ge_ll, c_sat, out_free, root_done;
  logic [SW-1:0]     op_a, op_b;
  logic              op_sub;
  logic              root_go;
  logic [XW-1:0]     root_val, c_ext;
  logic [ROOT_W:0]   root_try;
  logic [DIST_W-1:0] min_cur, min_new;

  assign entry_flags = seg_flags_t'(q_entry[ENTRY_W-1 -: FLAGS_W]);
  assign is_mul = (state_r == B_SQ_W) || (state_r == B_SQ_D) || (state_r == B_DOT) ||
                  (state_r == B_SQ_E) || (state_r == B_MUL_WL) || (state_r == B_MUL_DD);
  assign last_term = (state_r == B_MUL_WL) || (state_r == B_MUL_DD) || (k_r == TERM_LAST);
  assign mul_done  = mrun_r && (mulb_r == '0);
  assign term_done = is_mul && mul_done;
  assign ll_zero   = (ll_r == '0);
  assign d_nonpos  = acc_r[AW-1] || (acc_r == '0);
  assign dd_ge_ll  = (acc_r[SW-1:0] >= ll_r);
  assign c_ext     = XW'($unsigned(acc_r));
  assign c_sat     = (c_ext >= (XW'(ll_r) << ROOT_W));
  assign out_free  = !out_valid_r || !out_stall;
  assign root_done = ovf_r || (one_r == '0);
  assign root_try  = {1'b0, res_r} + {1'b0, one_r};
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  // Multiplier operand select
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state_r)
      B_SQ_W: begin
        op_a = SW'(mag(w_r[0]));
        op_b = SW'(mag(w_r[0]));
      end
      B_SQ_D: begin
        op_a = SW'(mag(d_r[0]));
        op_b = SW'(mag(d_r[0]));
      end
      B_DOT: begin
        op_a   = SW'(mag(w_r[0]));
        op_b   = SW'(mag(d_r[0]));
        op_sub = w_r[0][DW-1] ^ d_r[0][DW-1];
      end
      B_SQ_E: begin
        op_a = SW'(mag(e_r[0]));
        op_b = SW'(mag(e_r[0]));
      end
      B_MUL_WL: begin
        op_a = ww_r;
        op_b = ll_r;
      end
      B_MUL_DD: begin
        op_a   = dd_r;
        op_b   = dd_r;
        op_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (!q_empty) state_nxt = entry_flags.seg_valid ? B_SQ_W : B_OUT;
      B_SQ_W:   if (mul_done && last_term) state_nxt = B_SQ_D;
      B_SQ_D:   if (mul_done && last_term) state_nxt = B_CHK_L;
      B_CHK_L:  state_nxt = ll_zero ? B_ROOT : B_DOT;
      B_DOT:    if (mul_done && last_term) state_nxt = B_CHK_D;
      B_CHK_D: begin
        priority if (d_nonpos) state_nxt = B_ROOT;
        else if (dd_ge_ll)     state_nxt = B_SQ_E;
        else                   state_nxt = B_MUL_WL;
      end
      B_SQ_E:   if (mul_done && last_term) state_nxt = B_ROOT;
      B_MUL_WL: if (mul_done) state_nxt = B_MUL_DD;
      B_MUL_DD: if (mul_done) state_nxt = B_CHK_C;
      B_CHK_C:  state_nxt = c_sat ? B_ROOT : B_DIV;
      B_DIV:    if (cnt_r == '0) state_nxt = B_ROOT;
      B_ROOT:   if (root_done) state_nxt = B_OUT;
      B_OUT:    if (out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    flags_nxt     = flags_r;
    w_nxt         = w_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    mrun_nxt      = mrun_r;
    msub_nxt      = msub_r;
    mula_nxt      = mula_r;
    mulb_nxt      = mulb_r;
    acc_nxt       = acc_r;
    ww_nxt        = ww_r;
    ll_nxt        = ll_r;
    dd_nxt        = dd_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    one_nxt       = one_r;
    ovf_nxt       = ovf_r;
    seg_nxt       = seg_r;
    min_nxt       = min_r;
    out_seg_nxt   = out_seg_r;
    out_near_nxt  = out_near_r;
    out_sv_nxt    = out_sv_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    root_go       = 1'b0;
    root_val      = '0;
    min_cur       = flags_r.first ? DIST_MAX : min_r;
    min_new       = (flags_r.seg_valid && (seg_r < min_cur)) ? seg_r : min_cur;

    // Take a request from the queue
    if (q_pop) begin
      flags_nxt = entry_flags;
      for (int j = 0; j < 3; j++) begin
        w_nxt[j] = q_entry[(8 - j) * DW +: DW];
        d_nxt[j] = q_entry[(5 - j) * DW +: DW];
        e_nxt[j] = q_entry[(2 - j) * DW +: DW];
      end
      acc_nxt  = '0;
      k_nxt    = '0;
      mrun_nxt = 1'b0;
      seg_nxt  = '0;
    end

    // Shift-add multiply, one multiplier bit per cycle
    if (is_mul) begin
      if (!mrun_r) begin
        mula_nxt = AW'(op_a);
        mulb_nxt = op_b;
        msub_nxt = op_sub;
        mrun_nxt = 1'b1;
      end else if (mulb_r != '0) begin
        if (mulb_r[0]) acc_nxt = msub_r ? acc_r - mula_r : acc_r + mula_r;
        mula_nxt = mula_r << 1;
        mulb_nxt = mulb_r >> 1;
      end
    end

    // Term finished: rotate vectors, close out the sum
    if (term_done) begin
      mrun_nxt = 1'b0;
      k_nxt    = last_term ? 2'd0 : k_r + 2'd1;
      if (state_r == B_SQ_W || state_r == B_DOT) w_nxt = '{w_r[1], w_r[2], w_r[0]};
      if (state_r == B_SQ_D || state_r == B_DOT) d_nxt = '{d_r[1], d_r[2], d_r[0]};
      if (state_r == B_SQ_E) e_nxt = '{e_r[1], e_r[2], e_r[0]};
      if (last_term) begin
        if (state_r == B_SQ_W) begin
          ww_nxt  = acc_r[SW-1:0];
          acc_nxt = '0;
        end
        if (state_r == B_SQ_D) begin
          ll_nxt  = acc_r[SW-1:0];
          acc_nxt = '0;
        end
        if (state_r == B_SQ_E) begin
          root_go  = 1'b1;
          root_val = c_ext;
        end
      end
    end

    // Projection checks
    if (state_r == B_CHK_L && ll_zero) begin
      root_go  = 1'b1;
      root_val = XW'(ww_r);
    end
    if (state_r == B_CHK_D) begin
      if (d_nonpos) begin
        root_go  = 1'b1;
        root_val = XW'(ww_r);
      end else begin
        dd_nxt  = acc_r[SW-1:0];
        acc_nxt = '0;
      end
    end
    if (state_r == B_CHK_C) begin
      if (c_sat) begin
        root_go  = 1'b1;
        root_val = '1;
      end else begin
        rem_nxt = c_ext;
        dv_nxt  = XW'(ll_r) << (ROOT_W - 1);
        q_nxt   = '0;
        cnt_nxt = CNT_W'(ROOT_W - 1);
      end
    end

    // Restoring division, one quotient bit per cycle
    if (state_r == B_DIV) begin
      if (rem_r >= dv_r) begin
        rem_nxt        = rem_r - dv_r;
        q_nxt[cnt_r]   = 1'b1;
      end
      dv_nxt  = dv_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        root_go  = 1'b1;
        root_val = XW'(q_nxt);
      end
    end

    // Digit-by-digit integer root
    if (state_r == B_ROOT) begin
      if (root_done) begin
        seg_nxt = ovf_r ? DIST_MAX : res_r[DIST_W-1:0];
      end else begin
        if ({1'b0, x_r} >= root_try) begin
          x_nxt   = x_r - root_try[ROOT_W-1:0];
          res_nxt = (res_r >> 1) + one_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        one_nxt = one_r >> 2;
      end
    end

    if (root_go) begin
      x_nxt   = root_val[ROOT_W-1:0];
      ovf_nxt = |root_val[XW-1:ROOT_W];
      res_nxt = '0;
      one_nxt = ROOT_ONE;
    end

    // Result register and running minimum
    if (state_r == B_OUT && out_free) begin
      out_valid_nxt = 1'b1;
      out_seg_nxt   = seg_r;
      out_sv_nxt    = flags_r.seg_valid;
      out_near_nxt  = min_new;
      out_done_nxt  = flags_r.last;
      min_nxt       = flags_r.last ? DIST_MAX : min_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      k_r         <= '0;
      mrun_r      <= 1'b0;
      ovf_r       <= 1'b0;
      min_r       <= DIST_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      mrun_r      <= mrun_nxt;
      ovf_r       <= ovf_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    w_r        <= w_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    msub_r     <= msub_nxt;
    mula_r     <= mula_nxt;
    mulb_r     <= mulb_nxt;
    acc_r      <= acc_nxt;
    ww_r       <= ww_nxt;
    ll_r       <= ll_nxt;
    dd_r       <= dd_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    x_r        <= x_nxt;
    res_r      <= res_nxt;
    one_r      <= one_nxt;
    seg_r      <= seg_nxt;
    out_seg_r  <= out_seg_nxt;
    out_near_r <= out_near_nxt;
    out_sv_r   <= out_sv_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_segment_distance = out_seg_r;
  assign out_segment_valid    = out_sv_r;
  assign out_nearest_distance = out_near_r;
  assign out_polyline_done    = out_done_r;

  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == B_ROOT && !ovf_r) |-> $onehot0(one_r))
    else $error("root step bit not single");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == B_OUT && out_free) |=> out_valid_r)
    else $error("result not registered");
  a_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
      mrun_r |-> (state_r == B_SQ_W || state_r == B_SQ_D || state_r == B_DOT ||
                  state_r == B_SQ_E || state_r == B_MUL_WL || state_r == B_MUL_DD))
    else $error("multiplier running outside a multiply step");

endmodule

[sv/polyline_point_nearest_distance.sv]
// Top level: distance from a probe point to a 3D polyline, with running minimum.
// Path: an accepted vertex is registered into the queue and then taken by the back end,
// which takes no new vertex until its pass ends; a vertex with no segment goes straight
// to the result register. A segment's pass is set by the bit-serial shared multiplier
// (one multiplier bit per cycle), the restoring divider and the digit-by-digit root.
// Reset (rst_n, synchronous): probe 0, no previous vertex, running minimum all ones.
module polyline_point_nearest_distance #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex_z,
  input  logic                           in_first_vertex,
  input  logic                           in_last_vertex,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ppnd_pkg::DIST_W-1:0]    out_segment_distance,
  output logic                           out_segment_valid,
  output logic [ppnd_pkg::DIST_W-1:0]    out_nearest_distance,
  output logic                           out_polyline_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppnd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_data
);
  import ppnd_pkg::*;

  localparam int ENTRY_W = 9 * (COORD_WIDTH + 1) + FLAGS_W;

  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_in, q_out;

  ppnd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_vertex_z     (in_vertex_z),
    .in_first_vertex (in_first_vertex),
    .in_last_vertex  (in_last_vertex),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_entry         (q_in)
  );

  ppnd_fifo #(.WIDTH(ENTRY_W)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  ppnd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_entry              (q_out),
    .q_empty              (q_empty),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_segment_distance (out_segment_distance),
    .out_segment_valid    (out_segment_valid),
    .out_nearest_distance (out_nearest_distance),
    .out_polyline_done    (out_polyline_done)
  );

endmodule
